// ===== hw/rtl/slkt_pkg.sv =====
// Shared types and constants for the sorted leaf key table.
// Used by slkt_cell, slkt_ctrl, sorted_leaf_key_table and its checker.
`default_nettype none

package slkt_pkg;

  localparam int ENTRY_LIMIT_DEF = 31;
  localparam int KEY_BITS_DEF    = 32;
  localparam int VALUE_BITS_DEF  = 32;

  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  localparam int FIELD_W  = 32;
  localparam int COUNT_W  = 6;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_REMOVE = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_DUP     = 2'd1,
    ST_MISSING = 2'd2,
    ST_NOROOM  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DONE
  } state_t;

  // Write command broadcast to every cell for one cycle.
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/slkt_cell.sv =====
// One slot of the sorted table: holds a key/value record, compares it with
// the request and shifts from its left or right neighbor. Uses slkt_pkg.
`default_nettype none

module slkt_cell #(
  parameter int KEY_BITS   = slkt_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = slkt_pkg::VALUE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire slkt_pkg::cell_cmd_t   cmd,
  input  wire logic                  occupied,
  input  wire logic [KEY_BITS-1:0]   req_key,
  input  wire logic [VALUE_BITS-1:0] req_value,
  input  wire logic                  left_lt,
  input  wire logic [KEY_BITS-1:0]   left_key,
  input  wire logic [VALUE_BITS-1:0] left_value,
  input  wire logic [KEY_BITS-1:0]   right_key,
  input  wire logic [VALUE_BITS-1:0] right_value,
  output logic                       lt,
  output logic                       eq,
  output logic [KEY_BITS-1:0]        key,
  output logic [VALUE_BITS-1:0]      value
);

  logic [KEY_BITS-1:0]   key_r,   key_nxt;
  logic [VALUE_BITS-1:0] value_r, value_nxt;

  assign lt    = occupied && (key_r < req_key);
  assign eq    = occupied && (key_r == req_key);
  assign key   = key_r;
  assign value = value_r;

  always_comb begin
    key_nxt   = key_r;
    value_nxt = value_r;
    if (cmd.ins && !lt) begin
      // first slot not below the key takes the new record, later ones shift up
      if (left_lt) begin
        key_nxt   = req_key;
        value_nxt = req_value;
      end else begin
        key_nxt   = left_key;
        value_nxt = left_value;
      end
    end else if (cmd.rem && !lt) begin
      // close the gap from the removed slot on
      key_nxt   = right_key;
      value_nxt = right_value;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    value_r <= value_nxt;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/slkt_ctrl.sv =====
// Request sequencer for the sorted leaf key table: holds the request,
// record count and result, and issues the cell write command. Uses slkt_pkg.
`default_nettype none

module slkt_ctrl #(
  parameter int ENTRY_LIMIT = slkt_pkg::ENTRY_LIMIT_DEF,
  parameter int KEY_BITS    = slkt_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS  = slkt_pkg::VALUE_BITS_DEF,
  localparam int SLOTS      = ENTRY_LIMIT + 1,
  localparam int HALF       = (ENTRY_LIMIT + 1) / 2,
  localparam int CNT_W      = $clog2(SLOTS + 1)
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [slkt_pkg::OP_W-1:0]        in_operation,
  input  wire logic [slkt_pkg::FIELD_W-1:0]     in_search_key,
  input  wire logic [slkt_pkg::FIELD_W-1:0]     in_new_value,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [slkt_pkg::STATUS_W-1:0]         out_status,
  output logic [slkt_pkg::FIELD_W-1:0]          out_found_value,
  output logic [slkt_pkg::COUNT_W-1:0]          out_record_count,
  output logic                                  out_is_full,
  output logic                                  out_is_underflow,
  output logic                                  out_can_lend,
  input  wire logic                             hit,
  input  wire logic [VALUE_BITS-1:0]            hit_value,
  output slkt_pkg::cell_cmd_t                   cmd,
  output logic [CNT_W-1:0]                      count,
  output logic [KEY_BITS-1:0]                   req_key,
  output logic [VALUE_BITS-1:0]                 req_value
);

  slkt_pkg::state_t state_r, state_nxt;

  logic [slkt_pkg::OP_W-1:0]     op_r;
  logic [KEY_BITS-1:0]           key_r;
  logic [VALUE_BITS-1:0]         value_r;
  logic [CNT_W-1:0]              count_r, count_nxt;
  slkt_pkg::status_t             status_r, status_nxt;
  logic [slkt_pkg::FIELD_W-1:0]  found_r, found_nxt;
  logic                          full_r, under_r, lend_r;
  logic                          exec, do_ins, do_rem;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      slkt_pkg::S_IDLE: if (in_valid) state_nxt = slkt_pkg::S_EXEC;
      slkt_pkg::S_EXEC: state_nxt = slkt_pkg::S_DONE;
      slkt_pkg::S_DONE: if (out_ready) state_nxt = slkt_pkg::S_IDLE;
      default:          state_nxt = slkt_pkg::S_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    exec      = 1'b0;
    unique case (state_r)
      slkt_pkg::S_IDLE: in_ready  = 1'b1;
      slkt_pkg::S_EXEC: exec      = 1'b1;
      slkt_pkg::S_DONE: out_valid = 1'b1;
      default: ;
    endcase
  end

  // Decide the operation from the cells' match result
  always_comb begin
    status_nxt = slkt_pkg::ST_MISSING;
    found_nxt  = '0;
    count_nxt  = count_r;
    do_ins     = 1'b0;
    do_rem     = 1'b0;
    unique case (op_r)
      slkt_pkg::OP_INSERT: begin
        if (hit) begin
          status_nxt = slkt_pkg::ST_DUP;
        end else if (count_r >= CNT_W'(SLOTS)) begin
          status_nxt = slkt_pkg::ST_NOROOM;
        end else begin
          status_nxt = slkt_pkg::ST_OK;
          do_ins     = 1'b1;
          count_nxt  = count_r + CNT_W'(1);
        end
      end
      slkt_pkg::OP_LOOKUP: begin
        if (hit) begin
          status_nxt = slkt_pkg::ST_OK;
          found_nxt  = slkt_pkg::FIELD_W'(hit_value);
        end
      end
      slkt_pkg::OP_REMOVE: begin
        if (hit) begin
          status_nxt = slkt_pkg::ST_OK;
          do_rem     = 1'b1;
          count_nxt  = count_r - CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  assign cmd.ins   = exec && do_ins;
  assign cmd.rem   = exec && do_rem;
  assign count     = count_r;
  assign req_key   = key_r;
  assign req_value = value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= slkt_pkg::S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (exec) count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r    <= in_operation;
      key_r   <= KEY_BITS'(in_search_key);
      value_r <= VALUE_BITS'(in_new_value);
    end
    if (exec) begin
      status_r <= status_nxt;
      found_r  <= found_nxt;
      full_r   <= count_nxt > CNT_W'(ENTRY_LIMIT);
      under_r  <= count_nxt < CNT_W'(HALF);
      lend_r   <= count_nxt > CNT_W'(HALF);
    end
  end

  assign out_status       = status_r;
  assign out_found_value  = found_r;
  assign out_record_count = slkt_pkg::COUNT_W'(count_r);
  assign out_is_full      = full_r;
  assign out_is_underflow = under_r;
  assign out_can_lend     = lend_r;

endmodule

`default_nettype wire

// ===== hw/rtl/sorted_leaf_key_table.sv =====
// Sorted leaf key table: key/value records kept in ascending key order in a
// row of ENTRY_LIMIT+1 cells, one record per cell. Each request (insert,
// lookup, remove) is first accepted; then every cell compares its key
// with the request in parallel and shifts its record to or from a
// neighbor; then the result is held until taken. A new request is
// accepted only once the previous result is taken, so requests do not
// overlap. No clearing pass is needed after reset; the record count alone
// marks which cells hold records. Depends on slkt_pkg, slkt_cell and
// slkt_ctrl.
`default_nettype none

module sorted_leaf_key_table #(
  parameter int ENTRY_LIMIT = slkt_pkg::ENTRY_LIMIT_DEF,
  parameter int KEY_BITS    = slkt_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS  = slkt_pkg::VALUE_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [slkt_pkg::OP_W-1:0]        in_operation,
  input  wire logic [slkt_pkg::FIELD_W-1:0]     in_search_key,
  input  wire logic [slkt_pkg::FIELD_W-1:0]     in_new_value,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [slkt_pkg::STATUS_W-1:0]         out_status,
  output logic [slkt_pkg::FIELD_W-1:0]          out_found_value,
  output logic [slkt_pkg::COUNT_W-1:0]          out_record_count,
  output logic                                  out_is_full,
  output logic                                  out_is_underflow,
  output logic                                  out_can_lend
);

  localparam int SLOTS = ENTRY_LIMIT + 1;
  localparam int CNT_W = $clog2(SLOTS + 1);

  slkt_pkg::cell_cmd_t   cmd;
  logic [CNT_W-1:0]      count;
  logic [KEY_BITS-1:0]   req_key;
  logic [VALUE_BITS-1:0] req_value;

  logic [SLOTS-1:0]      lt, eq, occ;
  logic [KEY_BITS-1:0]   cell_key   [SLOTS];
  logic [VALUE_BITS-1:0] cell_value [SLOTS];
  logic [VALUE_BITS-1:0] masked     [SLOTS];
  logic                  hit;
  logic [VALUE_BITS-1:0] hit_value;

  slkt_ctrl #(
    .ENTRY_LIMIT (ENTRY_LIMIT),
    .KEY_BITS    (KEY_BITS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_search_key    (in_search_key),
    .in_new_value     (in_new_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_found_value  (out_found_value),
    .out_record_count (out_record_count),
    .out_is_full      (out_is_full),
    .out_is_underflow (out_is_underflow),
    .out_can_lend     (out_can_lend),
    .hit              (hit),
    .hit_value        (hit_value),
    .cmd              (cmd),
    .count            (count),
    .req_key          (req_key),
    .req_value        (req_value)
  );

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    logic                  l_lt;
    logic [KEY_BITS-1:0]   l_key, r_key;
    logic [VALUE_BITS-1:0] l_value, r_value;

    assign occ[i] = count > CNT_W'(i);

    // head cell sees everything to its left as below the key
    if (i == 0) begin : g_head
      assign l_lt    = 1'b1;
      assign l_key   = '0;
      assign l_value = '0;
    end else begin : g_mid
      assign l_lt    = lt[i-1];
      assign l_key   = cell_key[i-1];
      assign l_value = cell_value[i-1];
    end

    if (i == SLOTS - 1) begin : g_tail
      assign r_key   = '0;
      assign r_value = '0;
    end else begin : g_body
      assign r_key   = cell_key[i+1];
      assign r_value = cell_value[i+1];
    end

    slkt_cell #(
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .occupied    (occ[i]),
      .req_key     (req_key),
      .req_value   (req_value),
      .left_lt     (l_lt),
      .left_key    (l_key),
      .left_value  (l_value),
      .right_key   (r_key),
      .right_value (r_value),
      .lt          (lt[i]),
      .eq          (eq[i]),
      .key         (cell_key[i]),
      .value       (cell_value[i])
    );

    assign masked[i] = eq[i] ? cell_value[i] : '0;
  end

  // keys are unique, so at most one cell matches
  always_comb begin
    hit_value = '0;
    for (int j = 0; j < SLOTS; j++) begin
      hit_value = hit_value | masked[j];
    end
  end

  assign hit = |eq;

endmodule

`default_nettype wire

// ===== hw/rtl/slkt_checker.sv =====
// Port-level checker for sorted_leaf_key_table, bound to the top level.
// Depends on slkt_pkg.
`default_nettype none

module slkt_checker #(
  parameter int ENTRY_LIMIT = slkt_pkg::ENTRY_LIMIT_DEF
) (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_valid,
  input wire logic                             in_ready,
  input wire logic                             out_valid,
  input wire logic                             out_ready,
  input wire logic [slkt_pkg::STATUS_W-1:0]    out_status,
  input wire logic [slkt_pkg::FIELD_W-1:0]     out_found_value,
  input wire logic [slkt_pkg::COUNT_W-1:0]     out_record_count,
  input wire logic                             out_is_full,
  input wire logic                             out_is_underflow,
  input wire logic                             out_can_lend
);

  localparam int HALF = (ENTRY_LIMIT + 1) / 2;

  // hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_found_value) && $stable(out_record_count))
    else $error("result changed while stalled");

  a_no_value_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != slkt_pkg::ST_OK |-> out_found_value == '0)
    else $error("value reported on a failed request");

  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_is_full == (32'(out_record_count) > ENTRY_LIMIT)
      && out_is_underflow == (32'(out_record_count) < HALF)
      && out_can_lend == (32'(out_record_count) > HALF))
    else $error("flags disagree with record count");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("request taken while a result is pending");

  a_room_refused_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == slkt_pkg::ST_NOROOM |-> out_is_full)
    else $error("no room reported on a table that is not full");

endmodule

bind sorted_leaf_key_table slkt_checker #(
  .ENTRY_LIMIT (ENTRY_LIMIT)
) u_slkt_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_status       (out_status),
  .out_found_value  (out_found_value),
  .out_record_count (out_record_count),
  .out_is_full      (out_is_full),
  .out_is_underflow (out_is_underflow),
  .out_can_lend     (out_can_lend)
);

`default_nettype wire
